>>> hdl/ymr_pkg.sv
// ----------------------------------------------------------------------------
// ymr_pkg: shared types and constants of the YMODEM receiver
// Control characters, field codes, frame geometry, result item layout
// and the byte-wide CRC-16/XMODEM update.
// ----------------------------------------------------------------------------
package ymr_pkg;

	// frame geometry and protocol limits
	localparam int SHORT_PAYLOAD    = 128;
	localparam int LONG_PAYLOAD     = 1024;
	localparam int ABORT_CANCELS    = 5;
	localparam int TICKS_PER_SECOND = 1000;
	localparam int MAX_RES          = 3;

	// header is start byte, block number and its complement
	localparam int DATA_FIRST = 3;

	localparam int BP_W   = $clog2(LONG_PAYLOAD + DATA_FIRST + 2);
	localparam int MS_W   = $clog2(TICKS_PER_SECOND + 1);
	localparam int CR_W   = 3;
	localparam int RCNT_W = $clog2(MAX_RES + 1);
	localparam int RIDX_W = $clog2(MAX_RES);

	localparam logic [15:0] TIMEOUT_RESET = 16'd10;
	localparam logic [15:0] CRC_POLY      = 16'h1021;

	// line characters
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_C   = 8'h43;

	// input operation codes
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_REPLY   = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;
	localparam logic [1:0] KIND_SESSION = 2'd3;

	// status codes
	localparam logic [2:0] ST_RUNNING  = 3'd0;
	localparam logic [2:0] ST_FRAME_OK = 3'd1;
	localparam logic [2:0] ST_FRAME_BAD = 3'd2;
	localparam logic [2:0] ST_COMPLETE = 3'd3;
	localparam logic [2:0] ST_TIMEOUT  = 3'd4;
	localparam logic [2:0] ST_ABORTED  = 3'd5;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT_START,
		PH_WAIT_DATA,
		PH_WAIT_EOT2,
		PH_WAIT_END,
		PH_COMPLETE,
		PH_TIMEOUT,
		PH_ABORTED
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [7:0] block;
		logic [2:0] status;
	} res_t;

	// all result items of one input item
	typedef struct packed {
		res_t [MAX_RES-1:0]  ent;
		logic [RCNT_W-1:0]   cnt;
	} batch_t;

	function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] value,
			input logic [7:0] block, input logic [2:0] status);
		res_t r;
		r.kind   = kind;
		r.value  = value;
		r.block  = block;
		r.status = status;
		return r;
	endfunction

	// crc-16/xmodem over one byte, msb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> hdl/ymodem_receiver_top.sv
// An accepted item passes the input register, then the result register, before its
// first result shows; the protocol step itself is combinational.
// One item per cycle while the output is not stalled and each item gives at most
// one result; more results hold the single-result output port until all are taken.
// Reset (arst_n low): session idle, all counters and frame state cleared,
// timeout_seconds set to 10, no results pending.
// ----------------------------------------------------------------------------
// ymodem_receiver_top: YMODEM receiver with CRC-16 frame checking
// Takes line bytes, millisecond ticks and start commands as a stream and
// returns reply bytes, payload bytes, frame verdicts and session status.
// ----------------------------------------------------------------------------
module ymodem_receiver_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // rx_byte
	input  logic [1:0]   s_axis_tuser,   // op
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [23:0]  m_axis_tdata,   // value, block_number, status, zero fill
	output logic [1:0]   m_axis_tuser,   // kind
	output logic         m_axis_tlast
);

	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [7:0]         byte_s1;
	logic               take;
	logic               can_load;
	ymr_pkg::batch_t    batch;

	// item leaves the input register once its results fit
	assign take          = valid_s1 && ((batch.cnt == '0) || can_load);
	assign s_axis_tready = !valid_s1 || take;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1   <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	ymr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item_op   (op_s1),
		.item_byte (byte_s1),
		.take      (take),
		.batch     (batch)
	);

	ymr_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (take && (batch.cnt != '0)),
		.batch_in      (batch),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

>>> hdl/ymr_core.sv
// ----------------------------------------------------------------------------
// ymr_core: session state and per-item decision logic
// Holds the protocol state, evaluates one registered item against it and
// produces the batch of result items that the item causes.
// ----------------------------------------------------------------------------
module ymr_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic [1:0]         item_op,
	input  logic [7:0]         item_byte,
	input  logic               take,
	output ymr_pkg::batch_t    batch
);

	ymr_pkg::phase_t                phase_q, phase_d;
	logic [ymr_pkg::BP_W-1:0]       bp_q, bp_d;
	logic                           long_q, long_d;
	logic [7:0]                     block_q, block_d;
	logic                           hok_q, hok_d;
	logic                           fpn_q, fpn_d;
	logic [15:0]                    crc_q, crc_d;
	logic [7:0]                     crch_q, crch_d;
	logic [ymr_pkg::CR_W-1:0]       cr_q, cr_d;
	logic [ymr_pkg::MS_W-1:0]       ms_q, ms_d;
	logic [15:0]                    idle_q, idle_d;
	logic [15:0]                    timeout_q;

	logic                           is_active;
	logic                           in_frame;
	logic [ymr_pkg::BP_W-1:0]       data_end;
	logic                           pos_block;
	logic                           pos_cmpl;
	logic                           pos_data;
	logic                           pos_crch;
	logic                           pos_finish;
	logic                           ms_wrap;
	logic [15:0]                    idle_inc;
	logic                           timed_out;
	logic [ymr_pkg::CR_W-1:0]       cr_inc;
	logic                           abort_hit;
	logic                           phase_ok;
	logic                           frame_ok;
	logic [15:0]                    crc_next;

	// shared decode of state and item
	assign is_active  = (phase_q == ymr_pkg::PH_WAIT_START) || (phase_q == ymr_pkg::PH_WAIT_DATA)
		|| (phase_q == ymr_pkg::PH_WAIT_EOT2) || (phase_q == ymr_pkg::PH_WAIT_END);
	assign in_frame   = (bp_q != '0);
	assign data_end   = long_q ? ymr_pkg::BP_W'(ymr_pkg::DATA_FIRST + ymr_pkg::LONG_PAYLOAD)
		: ymr_pkg::BP_W'(ymr_pkg::DATA_FIRST + ymr_pkg::SHORT_PAYLOAD);
	assign pos_block  = (bp_q == ymr_pkg::BP_W'(1));
	assign pos_cmpl   = (bp_q == ymr_pkg::BP_W'(2));
	assign pos_data   = (bp_q >= ymr_pkg::BP_W'(ymr_pkg::DATA_FIRST)) && (bp_q < data_end);
	assign pos_crch   = (bp_q == data_end);
	assign pos_finish = (bp_q > data_end);
	assign ms_wrap    = (ms_q == ymr_pkg::MS_W'(ymr_pkg::TICKS_PER_SECOND - 1));
	assign idle_inc   = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
	assign timed_out  = (idle_inc > timeout_q);
	assign cr_inc     = (cr_q != '1) ? cr_q + ymr_pkg::CR_W'(1) : cr_q;
	assign abort_hit  = (cr_inc >= ymr_pkg::CR_W'(ymr_pkg::ABORT_CANCELS));
	assign crc_next   = ymr_pkg::crc16_byte(crc_q, item_byte);

	// start frame needs a file name, end frame an empty one
	always_comb begin
		if (phase_q == ymr_pkg::PH_WAIT_START) begin
			phase_ok = fpn_q;
		end else if (phase_q == ymr_pkg::PH_WAIT_END) begin
			phase_ok = !fpn_q;
		end else begin
			phase_ok = 1'b1;
		end
	end
	assign frame_ok = hok_q && ({crch_q, item_byte} == crc_q) && phase_ok;

	// next state
	always_comb begin
		phase_d = phase_q;
		bp_d    = bp_q;
		long_d  = long_q;
		block_d = block_q;
		hok_d   = hok_q;
		fpn_d   = fpn_q;
		crc_d   = crc_q;
		crch_d  = crch_q;
		cr_d    = cr_q;
		ms_d    = ms_q;
		idle_d  = idle_q;
		if (take) begin
			case (item_op)
				ymr_pkg::OP_START: begin
					phase_d = ymr_pkg::PH_WAIT_START;
					bp_d    = '0;
					long_d  = 1'b0;
					block_d = '0;
					hok_d   = 1'b0;
					fpn_d   = 1'b0;
					crc_d   = '0;
					crch_d  = '0;
					cr_d    = '0;
					ms_d    = '0;
					idle_d  = '0;
				end
				ymr_pkg::OP_TICK: begin
					ms_d = ms_wrap ? '0 : ms_q + ymr_pkg::MS_W'(1);
					if (ms_wrap && is_active) begin
						idle_d = idle_inc;
						if (timed_out) begin
							phase_d = ymr_pkg::PH_TIMEOUT;
							bp_d    = '0;
						end
					end
				end
				ymr_pkg::OP_BYTE: begin
					if (is_active && !in_frame) begin
						if (item_byte == ymr_pkg::CH_CAN) begin
							cr_d = cr_inc;
							if (abort_hit) begin
								phase_d = ymr_pkg::PH_ABORTED;
							end
						end else begin
							cr_d = '0;
							case (phase_q) inside
								ymr_pkg::PH_WAIT_START, ymr_pkg::PH_WAIT_END: begin
									if (item_byte == ymr_pkg::CH_SOH) begin
										long_d = 1'b0;
										bp_d   = ymr_pkg::BP_W'(1);
										crc_d  = '0;
										hok_d  = 1'b0;
										fpn_d  = 1'b0;
										crch_d = '0;
									end
								end
								ymr_pkg::PH_WAIT_DATA: begin
									if (item_byte == ymr_pkg::CH_EOT) begin
										phase_d = ymr_pkg::PH_WAIT_EOT2;
										idle_d  = '0;
									end else if ((item_byte == ymr_pkg::CH_SOH)
											|| (item_byte == ymr_pkg::CH_STX)) begin
										long_d = (item_byte == ymr_pkg::CH_STX);
										bp_d   = ymr_pkg::BP_W'(1);
										crc_d  = '0;
										hok_d  = 1'b0;
										fpn_d  = 1'b0;
										crch_d = '0;
									end
								end
								ymr_pkg::PH_WAIT_EOT2: begin
									if (item_byte == ymr_pkg::CH_EOT) begin
										phase_d = ymr_pkg::PH_WAIT_END;
										idle_d  = '0;
									end
								end
								default: begin
								end
							endcase
						end
					end else if (is_active) begin
						// inside a frame every byte is frame data
						cr_d = '0;
						if (pos_block) begin
							block_d = item_byte;
						end else if (pos_cmpl) begin
							hok_d = (item_byte == ~block_q);
						end else if (pos_data) begin
							if (bp_q == ymr_pkg::BP_W'(ymr_pkg::DATA_FIRST)) begin
								fpn_d = (item_byte != 8'h00);
							end
							crc_d = crc_next;
						end else if (pos_crch) begin
							crch_d = item_byte;
						end
						if (pos_finish) begin
							bp_d = '0;
							if (frame_ok) begin
								idle_d = '0;
								if (phase_q == ymr_pkg::PH_WAIT_START) begin
									phase_d = ymr_pkg::PH_WAIT_DATA;
								end else if (phase_q == ymr_pkg::PH_WAIT_END) begin
									phase_d = ymr_pkg::PH_COMPLETE;
								end
							end
						end else begin
							bp_d = bp_q + ymr_pkg::BP_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result items of the current item
	always_comb begin
		logic [ymr_pkg::RIDX_W-1:0] n;
		n = '0;
		batch.ent = '0;
		batch.cnt = '0;
		case (item_op)
			ymr_pkg::OP_START: begin
				batch.ent[n] = ymr_pkg::mk_res(ymr_pkg::KIND_REPLY, ymr_pkg::CH_C, 8'h00,
					ymr_pkg::ST_RUNNING);
				batch.cnt = ymr_pkg::RCNT_W'(1);
			end
			ymr_pkg::OP_TICK: begin
				if (ms_wrap && is_active) begin
					if (timed_out) begin
						batch.ent[n] = ymr_pkg::mk_res(ymr_pkg::KIND_SESSION, 8'h00, 8'h00,
							ymr_pkg::ST_TIMEOUT);
						batch.cnt = ymr_pkg::RCNT_W'(1);
					end else if ((phase_q == ymr_pkg::PH_WAIT_START) && !in_frame) begin
						batch.ent[n] = ymr_pkg::mk_res(ymr_pkg::KIND_REPLY, ymr_pkg::CH_C,
							8'h00, ymr_pkg::ST_RUNNING);
						batch.cnt = ymr_pkg::RCNT_W'(1);
					end
				end
			end
			ymr_pkg::OP_BYTE: begin
				if (is_active && !in_frame) begin
					if (item_byte == ymr_pkg::CH_CAN) begin
						if (abort_hit) begin
							batch.ent[n] = ymr_pkg::mk_res(ymr_pkg::KIND_SESSION, 8'h00,
								8'h00, ymr_pkg::ST_ABORTED);
							batch.cnt = ymr_pkg::RCNT_W'(1);
						end
					end else if (item_byte == ymr_pkg::CH_EOT) begin
						if (phase_q == ymr_pkg::PH_WAIT_DATA) begin
							batch.ent[n] = ymr_pkg::mk_res(ymr_pkg::KIND_REPLY,
								ymr_pkg::CH_NAK, 8'h00, ymr_pkg::ST_RUNNING);
							batch.cnt = ymr_pkg::RCNT_W'(1);
						end else if (phase_q == ymr_pkg::PH_WAIT_EOT2) begin
							batch.ent[n] = ymr_pkg::mk_res(ymr_pkg::KIND_REPLY,
								ymr_pkg::CH_ACK, 8'h00, ymr_pkg::ST_RUNNING);
							n = n + ymr_pkg::RIDX_W'(1);
							batch.ent[n] = ymr_pkg::mk_res(ymr_pkg::KIND_REPLY,
								ymr_pkg::CH_C, 8'h00, ymr_pkg::ST_RUNNING);
							batch.cnt = ymr_pkg::RCNT_W'(2);
						end
					end
				end else if (is_active) begin
					if (pos_data && (phase_q == ymr_pkg::PH_WAIT_DATA)) begin
						batch.ent[n] = ymr_pkg::mk_res(ymr_pkg::KIND_PAYLOAD, item_byte,
							block_q, ymr_pkg::ST_RUNNING);
						batch.cnt = ymr_pkg::RCNT_W'(1);
					end else if (pos_finish) begin
						batch.ent[n] = ymr_pkg::mk_res(ymr_pkg::KIND_VERDICT, 8'h00, block_q,
							frame_ok ? ymr_pkg::ST_FRAME_OK : ymr_pkg::ST_FRAME_BAD);
						batch.cnt = ymr_pkg::RCNT_W'(1);
						if (frame_ok) begin
							n = n + ymr_pkg::RIDX_W'(1);
							batch.ent[n] = ymr_pkg::mk_res(ymr_pkg::KIND_REPLY,
								ymr_pkg::CH_ACK, 8'h00, ymr_pkg::ST_RUNNING);
							batch.cnt = ymr_pkg::RCNT_W'(2);
							n = n + ymr_pkg::RIDX_W'(1);
							if (phase_q == ymr_pkg::PH_WAIT_START) begin
								batch.ent[n] = ymr_pkg::mk_res(ymr_pkg::KIND_REPLY,
									ymr_pkg::CH_C, 8'h00, ymr_pkg::ST_RUNNING);
								batch.cnt = ymr_pkg::RCNT_W'(3);
							end else if (phase_q == ymr_pkg::PH_WAIT_END) begin
								batch.ent[n] = ymr_pkg::mk_res(ymr_pkg::KIND_SESSION,
									8'h00, 8'h00, ymr_pkg::ST_COMPLETE);
								batch.cnt = ymr_pkg::RCNT_W'(3);
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ymr_pkg::PH_IDLE;
			bp_q    <= '0;
			long_q  <= 1'b0;
			block_q <= '0;
			hok_q   <= 1'b0;
			fpn_q   <= 1'b0;
			crc_q   <= '0;
			crch_q  <= '0;
			cr_q    <= '0;
			ms_q    <= '0;
			idle_q  <= '0;
		end else begin
			phase_q <= phase_d;
			bp_q    <= bp_d;
			long_q  <= long_d;
			block_q <= block_d;
			hok_q   <= hok_d;
			fpn_q   <= fpn_d;
			crc_q   <= crc_d;
			crch_q  <= crch_d;
			cr_q    <= cr_d;
			ms_q    <= ms_d;
			idle_q  <= idle_d;
		end
	end

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= ymr_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

`ifndef SYNTHESIS
	a_idle_bytes_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (item_op == ymr_pkg::OP_BYTE) && !is_active) |-> (batch.cnt == '0))
		else $error("byte outside a session produced a result");

	a_start_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (item_op == ymr_pkg::OP_START))
		|=> ((phase_q == ymr_pkg::PH_WAIT_START) && (bp_q == '0) && (idle_q == '0)))
		else $error("start command did not reset the session");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bp_q <= ymr_pkg::BP_W'(ymr_pkg::DATA_FIRST + ymr_pkg::LONG_PAYLOAD + 1))
		else $error("byte position ran past the frame end");
`endif

endmodule

>>> hdl/ymr_outbuf.sv
// ----------------------------------------------------------------------------
// ymr_outbuf: result register for one item's results
// Holds the up to three result items of one input item and hands them to
// the output stream one per cycle while the receiver is ready, marking the last of them.
// ----------------------------------------------------------------------------
module ymr_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ymr_pkg::batch_t  batch_in,
	output logic             can_load,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // value, block_number, status, zero fill
	output logic [1:0]       m_axis_tuser,   // kind
	output logic             m_axis_tlast
);

	ymr_pkg::res_t [ymr_pkg::MAX_RES-1:0]  ent_q;
	logic [ymr_pkg::RCNT_W-1:0]            cnt_q;
	logic                                  pop;

	assign pop      = (cnt_q != '0) && m_axis_tready;
	assign can_load = (cnt_q == '0) || ((cnt_q == ymr_pkg::RCNT_W'(1)) && m_axis_tready);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= batch_in.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - ymr_pkg::RCNT_W'(1);
		end
	end

	// result entries, head at index zero
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= batch_in.ent;
		end else if (pop) begin
			for (int i = 0; i < ymr_pkg::MAX_RES - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

	// output stream
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = {5'b0, ent_q[0].status, ent_q[0].block, ent_q[0].value};
	assign m_axis_tuser  = ent_q[0].kind;
	assign m_axis_tlast  = (cnt_q == ymr_pkg::RCNT_W'(1));

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (can_load && (batch_in.cnt != '0)))
		else $error("result batch loaded over pending results");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ymr_pkg::RCNT_W'(ymr_pkg::MAX_RES))
		else $error("result count out of range");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast && !load) |=> !m_axis_tvalid)
		else $error("results remain after the last item was taken");
`endif

endmodule
